// ===== hw/rtl/vfcm_pkg.sv =====
// Shared types, codes and the corner table of the voxel face culling mesher.
// Depends on nothing; vfcm_if and the mesher core import it.
`timescale 1ns / 1ps
`default_nettype none

package vfcm_pkg;

    // Field widths fixed by the item formats.
    localparam int COORD_W  = 4;
    localparam int COUNT_W  = 15;
    localparam int VBASE_W  = 17;
    localparam int CORNER_W = 12;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [2:0]         dir_t;
    typedef logic [1:0]         mode_t;
    typedef logic [1:0]         side_t;

    // Command modes.
    localparam mode_t MODE_WR_VOXEL  = 2'd0;
    localparam mode_t MODE_WR_BORDER = 2'd1;
    localparam mode_t MODE_CLR_COUNT = 2'd2;
    localparam mode_t MODE_SCAN      = 2'd3;

    // Border planes.
    localparam side_t SIDE_NEG_X = 2'd0;
    localparam side_t SIDE_POS_X = 2'd1;
    localparam side_t SIDE_NEG_Z = 2'd2;
    localparam side_t SIDE_POS_Z = 2'd3;

    // Face directions, in scan order.
    localparam dir_t DIR_TOP    = 3'd0;
    localparam dir_t DIR_BOTTOM = 3'd1;
    localparam dir_t DIR_RIGHT  = 3'd2;
    localparam dir_t DIR_LEFT   = 3'd3;
    localparam dir_t DIR_FRONT  = 3'd4;
    localparam dir_t DIR_BACK   = 3'd5;

    // Packed corner offsets of a face, corner 0 in the low bits.
    // Each corner is {dz, dy, dx}.
    function automatic logic [CORNER_W-1:0] corner_code(input dir_t dir);
        logic [CORNER_W-1:0] code;
        unique case (dir)
            DIR_TOP:    code = {3'd7, 3'd3, 3'd2, 3'd6};
            DIR_BOTTOM: code = {3'd5, 3'd1, 3'd0, 3'd4};
            DIR_RIGHT:  code = {3'd1, 3'd3, 3'd7, 3'd5};
            DIR_LEFT:   code = {3'd4, 3'd6, 3'd2, 3'd0};
            DIR_FRONT:  code = {3'd5, 3'd7, 3'd6, 3'd4};
            DIR_BACK:   code = {3'd0, 3'd2, 3'd3, 3'd1};
            default:    code = '0;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vfcm_if.sv =====
// Handshake channels of the voxel face culling mesher: command and face.
// Depends on vfcm_pkg for the field types.
`timescale 1ns / 1ps
`default_nettype none

interface vfcm_cmd_if;
    import vfcm_pkg::*;

    logic   valid;
    logic   ready;
    mode_t  mode;
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    logic   solid_bit;
    side_t  border_side;

    modport source (
        output valid, mode, pos_x, pos_y, pos_z, solid_bit, border_side,
        input  ready
    );
    modport sink (
        input  valid, mode, pos_x, pos_y, pos_z, solid_bit, border_side,
        output ready
    );
endinterface

interface vfcm_face_if;
    import vfcm_pkg::*;

    logic                valid;
    logic                ready;
    coord_t              face_x;
    coord_t              face_y;
    coord_t              face_z;
    dir_t                face_dir;
    logic [CORNER_W-1:0] corner_offsets;
    logic [VBASE_W-1:0]  vertex_base;
    logic                last_face;

    modport source (
        output valid, face_x, face_y, face_z, face_dir, corner_offsets,
               vertex_base, last_face,
        input  ready
    );
    modport sink (
        input  valid, face_x, face_y, face_z, face_dir, corner_offsets,
               vertex_base, last_face,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/voxel_face_culling_mesher_core.sv =====
// Channel   | Role   | Payload
// ----------+--------+-------------------------------------------------------
// cmd       | sink   | mode, pos_x, pos_y, pos_z, solid_bit, border_side
// face      | source | face_x/y/z, face_dir, corner_offsets, vertex_base, last
//
// Writes and counter clears take effect when the command is accepted. A scan then
// reads seven solidity bits (the voxel and its six neighbours, one per cycle through
// the registered read ports of the voxel and border memories), then emits one face
// per pending direction.
// After reset both memories are swept to their start values; cmd.ready is low
// meanwhile. A stalled face sink holds the face register and the scan waits.
// Depends on vfcm_pkg, vfcm_if and vfcm_ram.
`timescale 1ns / 1ps
`default_nettype none

module voxel_face_culling_mesher_core #(
    parameter int CHUNK_EDGE = 16
) (
    input wire logic     clk,
    input wire logic     rst_n,
    vfcm_cmd_if.sink     cmd,
    vfcm_face_if.source  face
);
    import vfcm_pkg::*;

    localparam int PLANE = CHUNK_EDGE * CHUNK_EDGE;
    localparam int VOX   = PLANE * CHUNK_EDGE;
    localparam int BRD   = 4 * PLANE;
    localparam int HALF  = CHUNK_EDGE / 2;
    localparam int VA    = $clog2(VOX);
    localparam int BA    = $clog2(BRD);
    localparam int CW    = $clog2(CHUNK_EDGE);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam logic [1:0] SRC_VOX  = 2'd0;
    localparam logic [1:0] SRC_BRD  = 2'd1;
    localparam logic [1:0] SRC_NONE = 2'd2;

    function automatic logic [VA-1:0] vox_addr(input int x, input int y, input int z);
        return VA'((x * CHUNK_EDGE + y) * CHUNK_EDGE + z);
    endfunction

    function automatic logic [BA-1:0] brd_addr(input int side, input int u, input int v);
        return BA'(side * PLANE + u * CHUNK_EDGE + v);
    endfunction

    // Control state.
    logic [1:0]         state_reg, state_next;
    logic [2:0]         step_reg, step_next;
    logic [1:0]         src_reg, src_next;
    logic               center_reg, center_next;
    logic [5:0]         mask_reg, mask_next;
    logic [COUNT_W-1:0] face_count_reg, face_count_next;
    logic               face_valid_reg, face_valid_next;
    logic [VA:0]        vswp_reg;
    logic [BA:0]        bswp_reg;
    logic [CW-1:0]      sy_reg, sz_reg;

    // Payload registers.
    coord_t              x_reg, y_reg, z_reg;
    coord_t              fx_reg, fy_reg, fz_reg;
    dir_t                fdir_reg;
    logic [CORNER_W-1:0] fcorner_reg;
    logic [VBASE_W-1:0]  fbase_reg;
    logic                flast_reg;

    // Memory ports.
    logic          vox_we, vox_wdata, vox_rdata;
    logic [VA-1:0] vox_waddr, vox_raddr;
    logic          brd_we, brd_wdata, brd_rdata;
    logic [BA-1:0] brd_waddr, brd_raddr;

    logic       vox_sweep, brd_sweep, sweeping;
    logic       cmd_fire, in_range, brd_ok;
    logic [2:0] issue_dir, cap_dir;
    logic [1:0] src_issue;
    logic       cap_bit;
    logic       slot_free, load;
    dir_t       sel_dir;
    logic [5:0] mask_rest;

    assign vox_sweep = 32'(vswp_reg) < VOX;
    assign brd_sweep = 32'(bswp_reg) < BRD;
    assign sweeping  = vox_sweep || brd_sweep;

    assign cmd.ready = (state_reg == ST_IDLE) && !sweeping;
    assign cmd_fire  = cmd.valid && cmd.ready;

    assign in_range = (32'(cmd.pos_x) < CHUNK_EDGE) && (32'(cmd.pos_y) < CHUNK_EDGE)
                   && (32'(cmd.pos_z) < CHUNK_EDGE);

    // Border write address: x-side planes index by (y, z), z-side by (x, y).
    always_comb
    begin
        int a;
        int s;
        s = int'(cmd.border_side);
        a = (cmd.border_side == SIDE_NEG_X || cmd.border_side == SIDE_POS_X)
            ? int'(cmd.pos_z) : int'(cmd.pos_x);
        brd_ok = (a < CHUNK_EDGE) && (32'(cmd.pos_y) < CHUNK_EDGE);
        if (cmd.border_side == SIDE_NEG_X || cmd.border_side == SIDE_POS_X)
        begin
            brd_waddr = brd_sweep ? bswp_reg[BA-1:0] : brd_addr(s, int'(cmd.pos_y), a);
        end
        else
        begin
            brd_waddr = brd_sweep ? bswp_reg[BA-1:0] : brd_addr(s, a, int'(cmd.pos_y));
        end
    end

    assign brd_we    = brd_sweep || (cmd_fire && cmd.mode == MODE_WR_BORDER && brd_ok);
    assign brd_wdata = brd_sweep ? 1'b0 : cmd.solid_bit;

    // Voxel writes: the start-up sweep fills the lower half solid.
    assign vox_we    = vox_sweep || (cmd_fire && cmd.mode == MODE_WR_VOXEL && in_range);
    assign vox_waddr = vox_sweep ? vswp_reg[VA-1:0]
                     : vox_addr(int'(cmd.pos_x), int'(cmd.pos_y), int'(cmd.pos_z));
    assign vox_wdata = vox_sweep ? (32'(sy_reg) < HALF) : cmd.solid_bit;

    // Read address of the current step: step 0 is the voxel itself, steps 1 to 6
    // are its neighbours in scan order.
    assign issue_dir = step_reg - 3'd1;

    always_comb
    begin
        int cx;
        int cy;
        int cz;
        cx = int'(x_reg);
        cy = int'(y_reg);
        cz = int'(z_reg);
        vox_raddr = vox_addr(cx, cy, cz);
        brd_raddr = '0;
        src_issue = SRC_VOX;
        if (step_reg != 3'd0)
        begin
            unique case (issue_dir)
                DIR_TOP:
                    if (cy + 1 >= CHUNK_EDGE) src_issue = SRC_NONE;
                    else vox_raddr = vox_addr(cx, cy + 1, cz);
                DIR_BOTTOM:
                    if (cy == 0) src_issue = SRC_NONE;
                    else vox_raddr = vox_addr(cx, cy - 1, cz);
                DIR_RIGHT:
                    if (cx + 1 >= CHUNK_EDGE)
                    begin
                        src_issue = SRC_BRD;
                        brd_raddr = brd_addr(int'(SIDE_POS_X), cy, cz);
                    end
                    else vox_raddr = vox_addr(cx + 1, cy, cz);
                DIR_LEFT:
                    if (cx == 0)
                    begin
                        src_issue = SRC_BRD;
                        brd_raddr = brd_addr(int'(SIDE_NEG_X), cy, cz);
                    end
                    else vox_raddr = vox_addr(cx - 1, cy, cz);
                DIR_FRONT:
                    if (cz + 1 >= CHUNK_EDGE)
                    begin
                        src_issue = SRC_BRD;
                        brd_raddr = brd_addr(int'(SIDE_POS_Z), cx, cy);
                    end
                    else vox_raddr = vox_addr(cx, cy, cz + 1);
                DIR_BACK:
                    if (cz == 0)
                    begin
                        src_issue = SRC_BRD;
                        brd_raddr = brd_addr(int'(SIDE_NEG_Z), cx, cy);
                    end
                    else vox_raddr = vox_addr(cx, cy, cz - 1);
                default:
                    src_issue = SRC_NONE;
            endcase
        end
    end

    // Solidity bit returned for the previous step.
    assign cap_dir = step_reg - 3'd2;
    assign cap_bit = (src_reg == SRC_VOX) ? vox_rdata
                   : (src_reg == SRC_BRD) ? brd_rdata : 1'b0;

    // Lowest pending face direction.
    always_comb
    begin
        sel_dir = DIR_TOP;
        for (int i = 5; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                sel_dir = dir_t'(i);
            end
        end
        mask_rest = mask_reg & ~(6'd1 << sel_dir);
    end

    assign slot_free = !face_valid_reg || face.ready;
    assign load      = (state_reg == ST_EMIT) && slot_free;

    // Sequencer next state.
    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        src_next        = src_reg;
        center_next     = center_reg;
        mask_next       = mask_reg;
        face_count_next = face_count_reg;
        face_valid_next = face_valid_reg && !face.ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire && cmd.mode == MODE_CLR_COUNT)
                begin
                    face_count_next = '0;
                end
                if (cmd_fire && cmd.mode == MODE_SCAN && in_range)
                begin
                    state_next = ST_READ;
                    step_next  = 3'd0;
                    mask_next  = '0;
                end
            end
            ST_READ:
            begin
                src_next  = src_issue;
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd1)
                begin
                    center_next = cap_bit;
                end
                else if (step_reg != 3'd0)
                begin
                    mask_next[cap_dir] = !cap_bit;
                end
                if (step_reg == 3'd7)
                begin
                    state_next = (center_reg && mask_next != '0) ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    face_valid_next = 1'b1;
                    mask_next       = mask_rest;
                    face_count_next = face_count_reg + COUNT_W'(1);
                    if (mask_rest == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control registers and start-up sweep counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            src_reg        <= SRC_NONE;
            center_reg     <= 1'b0;
            mask_reg       <= '0;
            face_count_reg <= '0;
            face_valid_reg <= 1'b0;
            vswp_reg       <= '0;
            bswp_reg       <= '0;
            sy_reg         <= '0;
            sz_reg         <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            src_reg        <= src_next;
            center_reg     <= center_next;
            mask_reg       <= mask_next;
            face_count_reg <= face_count_next;
            face_valid_reg <= face_valid_next;
            if (brd_sweep)
            begin
                bswp_reg <= bswp_reg + (BA+1)'(1);
            end
            if (vox_sweep)
            begin
                vswp_reg <= vswp_reg + (VA+1)'(1);
                if (sz_reg == CW'(CHUNK_EDGE - 1))
                begin
                    sz_reg <= '0;
                    sy_reg <= (sy_reg == CW'(CHUNK_EDGE - 1)) ? '0 : sy_reg + CW'(1);
                end
                else
                begin
                    sz_reg <= sz_reg + CW'(1);
                end
            end
        end
    end

    // Captured voxel position and the face register.
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            x_reg <= cmd.pos_x;
            y_reg <= cmd.pos_y;
            z_reg <= cmd.pos_z;
        end
        if (load)
        begin
            fx_reg      <= x_reg;
            fy_reg      <= y_reg;
            fz_reg      <= z_reg;
            fdir_reg    <= sel_dir;
            fcorner_reg <= corner_code(sel_dir);
            fbase_reg   <= {face_count_reg, 2'b00};
            flast_reg   <= (mask_rest == '0);
        end
    end

    assign face.valid          = face_valid_reg;
    assign face.face_x         = fx_reg;
    assign face.face_y         = fy_reg;
    assign face.face_z         = fz_reg;
    assign face.face_dir       = fdir_reg;
    assign face.corner_offsets = fcorner_reg;
    assign face.vertex_base    = fbase_reg;
    assign face.last_face      = flast_reg;

    vfcm_ram #(.WIDTH(1), .DEPTH(VOX)) u_vox_ram (
        .clk   (clk),
        .we    (vox_we),
        .waddr (vox_waddr),
        .wdata (vox_wdata),
        .raddr (vox_raddr),
        .rdata (vox_rdata)
    );

    vfcm_ram #(.WIDTH(1), .DEPTH(BRD)) u_brd_ram (
        .clk   (clk),
        .we    (brd_we),
        .waddr (brd_waddr),
        .wdata (brd_wdata),
        .raddr (brd_raddr),
        .rdata (brd_rdata)
    );

    // Faces are emitted only for a solid voxel with pending faces.
    a_emit_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (center_reg && mask_reg != '0))
        else $error("emit state without a pending face");

    // Each loaded face advances the counter by one.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (face_count_reg == $past(face_count_reg) + COUNT_W'(1)))
        else $error("face counter did not advance");

    // No command is taken and no face is shown during the start-up sweep.
    a_sweep_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        sweeping |-> (!cmd.ready && !face_valid_reg))
        else $error("activity during start-up sweep");

    // The last face of a scan returns the sequencer to idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (load && mask_rest == '0) |=> (state_reg == ST_IDLE && flast_reg))
        else $error("last face did not end the scan");

endmodule

`default_nettype wire

// ===== hw/rtl/vfcm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module vfcm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
